FILE: rtl/core/dpas_pkg.sv
// Shared types, codes and constants for the delta patch apply stream block.
`timescale 1ns / 1ps

package dpas_pkg;

  // Default size width; magnitudes hold SIZE_BITS-1 bits
  localparam int SIZE_BITS_DEF = 32;

  // Patch length register reset value
  localparam logic [31:0] PATCH_LEN_RST = 32'hFFFF_FFFF;

  // Header codes
  localparam logic [2:0] TYPE_NORMAL   = 3'd0;
  localparam logic [2:0] TYPE_IN_PLACE = 3'd1;
  localparam logic [3:0] COMP_NONE     = 4'd0;

  // Varint shift bookkeeping
  localparam logic [5:0] SHIFT_FIRST = 6'd6;
  localparam logic [6:0] SHIFT_STEP  = 7'd7;
  localparam logic [5:0] SHIFT_MAX   = 6'd63;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TYPE = 3'd1,
    ST_IN_PLACE = 3'd2,
    ST_BAD_COMP = 3'd3,
    ST_CORRUPT  = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [7:0] {
    PH_HEADER     = 8'b0000_0001,
    PH_TSIZE      = 8'b0000_0010,
    PH_DIFF_SIZE  = 8'b0000_0100,
    PH_DIFF_DATA  = 8'b0000_1000,
    PH_EXTRA_SIZE = 8'b0001_0000,
    PH_EXTRA_DATA = 8'b0010_0000,
    PH_ADJUST     = 8'b0100_0000,
    PH_DONE       = 8'b1000_0000
  } phase_t;

  // Varint decoder control state
  typedef struct packed {
    logic       active;
    logic       negative;
    logic       over;
    logic [5:0] shift;
  } varint_ctl_t;

  // One result item
  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [31:0] from_addr;
    status_t     status;
    logic        done;
  } res_t;

endpackage

FILE: rtl/core/dpas_varint.sv
// Sign-magnitude varint decoder: folds one patch byte into the running value.
`timescale 1ns / 1ps

module dpas_varint #(
  parameter int SIZE_BITS = dpas_pkg::SIZE_BITS_DEF
) (
  input  logic [7:0]                 patch_byte,
  input  dpas_pkg::varint_ctl_t      ctl_in,
  input  logic [SIZE_BITS-2:0]       val_in,
  output dpas_pkg::varint_ctl_t      ctl_out,
  output logic [SIZE_BITS-2:0]       val_out,
  output logic                       complete
);

  localparam int MAG_BITS = SIZE_BITS - 1;
  localparam int WIDE_W   = MAG_BITS + 7;

  logic [6:0]        piece;
  logic [WIDE_W-1:0] wide;
  logic [6:0]        shift_sum;

  assign piece     = patch_byte[6:0];
  assign wide      = WIDE_W'(piece) << ctl_in.shift;
  assign shift_sum = {1'b0, ctl_in.shift} + dpas_pkg::SHIFT_STEP;
  assign complete  = !patch_byte[7];

  // First byte carries sign and six bits; later bytes seven bits each
  always_comb begin
    ctl_out = ctl_in;
    val_out = val_in;
    if (!ctl_in.active) begin
      ctl_out.negative = patch_byte[6];
      val_out          = MAG_BITS'(patch_byte[5:0]);
      ctl_out.shift    = dpas_pkg::SHIFT_FIRST;
      ctl_out.over     = 1'b0;
      ctl_out.active   = 1'b1;
    end else begin
      if (piece != 7'd0) begin
        if (ctl_in.shift >= 6'(MAG_BITS)) begin
          ctl_out.over = 1'b1;
        end else begin
          if (|wide[WIDE_W-1:MAG_BITS]) begin
            ctl_out.over = 1'b1;
          end
          val_out = val_in | wide[MAG_BITS-1:0];
        end
      end
      ctl_out.shift = (shift_sum > {1'b0, dpas_pkg::SHIFT_MAX}) ?
                      dpas_pkg::SHIFT_MAX : shift_sum[5:0];
    end
    // Continuation bit clear ends the varint
    if (complete) begin
      ctl_out.active = 1'b0;
    end
  end

endmodule

FILE: rtl/core/dpas_engine.sv
// Patch parser state and per-byte step logic producing one result per byte.
`timescale 1ns / 1ps

module dpas_engine #(
  parameter int SIZE_BITS = dpas_pkg::SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         patch_byte,
  input  logic [7:0]         from_byte,
  input  logic [31:0]        patch_length,
  output dpas_pkg::res_t     res
);

  localparam int MAG_BITS = SIZE_BITS - 1;

  dpas_pkg::phase_t      phase, phase_next;
  dpas_pkg::status_t     error_code, error_code_next;
  dpas_pkg::varint_ctl_t vctl, vctl_next, vi_ctl;
  logic [MAG_BITS-1:0]   target_size, target_size_next;
  logic [MAG_BITS-1:0]   target_pos, target_pos_next;
  logic [MAG_BITS-1:0]   section_left, section_left_next;
  logic [MAG_BITS-1:0]   varint_value, varint_value_next, vi_val;
  logic [31:0]           old_pos, old_pos_next;
  logic [31:0]           bytes_seen, bytes_seen_next;
  logic                  vi_done;
  logic                  size_bad;
  logic [MAG_BITS+31:0]  off_ext;
  logic [31:0]           off;
  dpas_pkg::status_t     st;
  logic                  ovalid;
  logic [7:0]            obyte;

  dpas_varint #(
    .SIZE_BITS (SIZE_BITS)
  ) u_varint (
    .patch_byte (patch_byte),
    .ctl_in     (vctl),
    .val_in     (varint_value),
    .ctl_out    (vi_ctl),
    .val_out    (vi_val),
    .complete   (vi_done)
  );

  // Section size checks against the bytes still to produce
  assign size_bad = vi_ctl.over || (vi_ctl.negative && (vi_val != '0)) ||
                    (vi_val > (target_size - target_pos));

  // Seek offset is the low 32 bits of the magnitude
  assign off_ext = (MAG_BITS + 32)'(vi_val);
  assign off     = off_ext[31:0];

  // Step logic for one patch byte
  always_comb begin
    phase_next        = phase;
    error_code_next   = error_code;
    vctl_next         = vctl;
    varint_value_next = varint_value;
    target_size_next  = target_size;
    target_pos_next   = target_pos;
    section_left_next = section_left;
    old_pos_next      = old_pos;
    bytes_seen_next   = bytes_seen;
    st                = dpas_pkg::ST_OK;
    ovalid            = 1'b0;
    obyte             = 8'd0;
    if (error_code != dpas_pkg::ST_OK) begin
      st = error_code;
    end else if (phase == dpas_pkg::PH_DONE) begin
      st = dpas_pkg::ST_DONE;
    end else if (bytes_seen >= patch_length) begin
      st = dpas_pkg::ST_CORRUPT;
    end else begin
      bytes_seen_next = bytes_seen + 32'd1;
      case (phase)
        dpas_pkg::PH_HEADER: begin
          if (patch_byte[6:4] == dpas_pkg::TYPE_NORMAL) begin
            st = (patch_byte[3:0] != dpas_pkg::COMP_NONE) ?
                 dpas_pkg::ST_BAD_COMP : dpas_pkg::ST_OK;
          end else if (patch_byte[6:4] == dpas_pkg::TYPE_IN_PLACE) begin
            st = dpas_pkg::ST_IN_PLACE;
          end else begin
            st = dpas_pkg::ST_BAD_TYPE;
          end
          if (st == dpas_pkg::ST_OK) begin
            phase_next = dpas_pkg::PH_TSIZE;
          end
        end
        dpas_pkg::PH_TSIZE: begin
          vctl_next         = vi_ctl;
          varint_value_next = vi_val;
          if (vi_done) begin
            if (vi_ctl.over || vi_ctl.negative || (vi_val == '0)) begin
              st = dpas_pkg::ST_CORRUPT;
            end else begin
              target_size_next = vi_val;
              target_pos_next  = '0;
              phase_next       = dpas_pkg::PH_DIFF_SIZE;
            end
          end
        end
        dpas_pkg::PH_DIFF_SIZE, dpas_pkg::PH_EXTRA_SIZE: begin
          vctl_next         = vi_ctl;
          varint_value_next = vi_val;
          if (vi_done) begin
            if (size_bad) begin
              st = dpas_pkg::ST_CORRUPT;
            end else begin
              section_left_next = vi_val;
              // Empty sections are skipped straight away
              if (vi_val != '0) begin
                phase_next = (phase == dpas_pkg::PH_DIFF_SIZE) ?
                             dpas_pkg::PH_DIFF_DATA : dpas_pkg::PH_EXTRA_DATA;
              end else begin
                phase_next = (phase == dpas_pkg::PH_DIFF_SIZE) ?
                             dpas_pkg::PH_EXTRA_SIZE : dpas_pkg::PH_ADJUST;
              end
            end
          end
        end
        dpas_pkg::PH_DIFF_DATA, dpas_pkg::PH_EXTRA_DATA: begin
          ovalid = 1'b1;
          if (phase == dpas_pkg::PH_DIFF_DATA) begin
            obyte        = patch_byte + from_byte;
            old_pos_next = old_pos + 32'd1;
          end else begin
            obyte = patch_byte;
          end
          target_pos_next   = target_pos + MAG_BITS'(1);
          section_left_next = section_left - MAG_BITS'(1);
          if (section_left == MAG_BITS'(1)) begin
            phase_next = (phase == dpas_pkg::PH_DIFF_DATA) ?
                         dpas_pkg::PH_EXTRA_SIZE : dpas_pkg::PH_ADJUST;
          end
        end
        dpas_pkg::PH_ADJUST: begin
          vctl_next         = vi_ctl;
          varint_value_next = vi_val;
          if (vi_done) begin
            if (vi_ctl.over) begin
              st = dpas_pkg::ST_CORRUPT;
            end else begin
              old_pos_next = vi_ctl.negative ? (old_pos - off) : (old_pos + off);
              phase_next   = (target_pos == target_size) ?
                             dpas_pkg::PH_DONE : dpas_pkg::PH_DIFF_SIZE;
            end
          end
        end
        default: begin
          st = dpas_pkg::ST_CORRUPT;
        end
      endcase
    end
    // Any failure becomes sticky
    if (st != dpas_pkg::ST_OK) begin
      error_code_next = st;
    end
  end

  // Result of this step
  always_comb begin
    res.out_valid = ovalid;
    res.out_byte  = obyte;
    res.from_addr = old_pos_next;
    res.status    = st;
    res.done      = (phase_next == dpas_pkg::PH_DONE);
  end

  // State registers advance once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dpas_pkg::PH_HEADER;
      error_code   <= dpas_pkg::ST_OK;
      vctl         <= '0;
      varint_value <= '0;
      target_size  <= '0;
      target_pos   <= '0;
      section_left <= '0;
      old_pos      <= '0;
      bytes_seen   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      error_code   <= error_code_next;
      vctl         <= vctl_next;
      varint_value <= varint_value_next;
      target_size  <= target_size_next;
      target_pos   <= target_pos_next;
      section_left <= section_left_next;
      old_pos      <= old_pos_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

endmodule

FILE: rtl/core/delta_patch_apply_stream.sv
// Path: a byte is captured in the input register, then its parser step result is captured in the result register.
// Throughput: one patch byte per cycle while m_tready holds; the parser step sits between the input
// register and the result register and updates its state in the same cycle.
// Reset (rst, synchronous, active high) returns the parser to the header phase,
// clears the sticky error and sets patch_length to all ones.
`timescale 1ns / 1ps

module delta_patch_apply_stream #(
  parameter int SIZE_BITS = dpas_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Patch byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // patch_byte[7:0], from_byte[15:8]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_byte[7:0], from_addr[39:8], status[42:40],
                                 // done_res[43], zero[47:44]
  output logic        m_tuser,   // out_valid[0]
  // patch_length register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic           in_valid_q;
  logic [7:0]     patch_q;
  logic [7:0]     from_q;
  logic           advance;
  logic           step;
  logic [31:0]    patch_length;
  dpas_pkg::res_t res_d;
  dpas_pkg::res_t res_q;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_length <= dpas_pkg::PATCH_LEN_RST;
    end else if (cfg_valid) begin
      patch_length <= cfg_data;
    end
  end

  // Handshake: input register moves on whenever the result slot frees
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid_q && advance;
  assign s_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      patch_q <= s_tdata[7:0];
      from_q  <= s_tdata[15:8];
    end
  end

  dpas_engine #(
    .SIZE_BITS (SIZE_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .patch_byte   (patch_q),
    .from_byte    (from_q),
    .patch_length (patch_length),
    .res          (res_d)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_tdata = {4'd0, res_q.done, res_q.status, res_q.from_addr, res_q.out_byte};
  assign m_tuser = res_q.out_valid;

  // A processed byte always lands in the result slot
  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed byte did not reach the result register");

  // A stalled input byte is neither lost nor altered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(patch_q) && $stable(from_q)))
    else $error("input register changed while stalled");

  // Target bytes only come with an ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_q.out_valid) |-> (res_q.status == dpas_pkg::ST_OK))
    else $error("target byte with error status");

  // A target byte never finishes the image by itself
  a_byte_not_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_q.out_valid) |-> !res_q.done)
    else $error("target byte flagged done");

endmodule
